// ----- src/throughput_floor_tracker_defines.svh -----
// Assertion macros shared by the throughput floor tracker checkers.
// Each macro expects a signal named clock, and the first two also one named reset, in the scope where it is used.
`ifndef THROUGHPUT_FLOOR_TRACKER_DEFINES_SVH
`define THROUGHPUT_FLOOR_TRACKER_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent, outside reset.
`define TFT_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("throughput floor tracker: same-cycle check failed");

// The consequent holds in the cycle after the antecedent, outside reset.
`define TFT_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("throughput floor tracker: next-cycle check failed");

// Checks that apply across reset itself, such as the state that reset leaves.
`define TFT_ASSERT_RESET(name, ante, cons) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("throughput floor tracker: reset check failed");

`endif

// ----- src/tft_pkg.sv -----
// Shared types and constants for the throughput floor tracker.
// No dependencies; every other file of the block but the divider and the macro header imports this package.
`default_nettype none

package tft_pkg;

   // Field widths of requests, results and configuration registers.
   localparam int COUNT_W     = 48;
   localparam int ELAPSED_W   = 32;
   localparam int RATE_W      = 48;
   localparam int FLOOR_W     = 47;
   localparam int RATIO_W     = 16;
   localparam int INTERVAL_W  = 16;
   localparam int MIN_FLOOR_W = 32;
   localparam int MODE_W      = 2;

   // Configuration port geometry.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // Milliseconds to seconds scale and the width of the scaled byte delta.
   localparam int RATE_SCALE = 1000;
   localparam int SCALE_W    = 10;
   localparam int PROD_W     = COUNT_W + SCALE_W;

   // Saturation limits of a signed rate.
   localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
   localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

   // Reset values of the configuration registers.
   localparam logic [INTERVAL_W-1:0]  RST_MIN_INTERVAL = 16'd100;
   localparam logic [MIN_FLOOR_W-1:0] RST_MIN_FLOOR    = 32'd1048576;
   localparam logic [RATIO_W-1:0]     RST_FLOOR_RATIO  = 16'd55706;

   // Request kinds.
   typedef enum logic [MODE_W-1:0] {
      MODE_TICK   = 2'd0,
      MODE_START  = 2'd1,
      MODE_RESUME = 2'd2
   } mode_type;

   // Configuration register indexes (byte address divided by four).
   typedef enum logic [1:0] {
      REG_MIN_INTERVAL = 2'd0,
      REG_MIN_FLOOR    = 2'd1,
      REG_FLOOR_RATIO  = 2'd2
   } reg_index_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RATE_GO,
      ST_RATE_WAIT,
      ST_PUSH,
      ST_WALK,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_FLOOR_MUL,
      ST_FLOOR
   } state_type;

   // Commands from the sequencer to the history buffer.
   typedef struct packed {
      logic clear;
      logic push;
      logic walk_start;
   } hist_ctl_type;

endpackage

`default_nettype wire

// ----- src/tft_if.sv -----
// Request and result channel interfaces of the throughput floor tracker.
// Depends on tft_pkg for the field widths.
`default_nettype none

// Request channel: one tick, start or resume request per handshake.
interface tft_req_if import tft_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic [ELAPSED_W-1:0] elapsed_ms;
   logic [COUNT_W-1:0]   byte_count;

   modport source (output valid, output mode, output elapsed_ms, output byte_count,
                   input ready);
   modport sink   (input valid, input mode, input elapsed_ms, input byte_count,
                   output ready);
endinterface

// Result channel: one result per accepted tick.
interface tft_rsp_if import tft_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [RATE_W-1:0] sample_bps;
   logic signed [RATE_W-1:0] average_bps;
   logic signed [RATE_W-1:0] smoothed_bps;
   logic [FLOOR_W-1:0]       floor_bps;
   logic                     below_floor;

   modport source (output valid, output sample_bps, output average_bps,
                   output smoothed_bps, output floor_bps, output below_floor,
                   input ready);
   modport sink   (input valid, input sample_bps, input average_bps,
                   input smoothed_bps, input floor_bps, input below_floor,
                   output ready);
endinterface

`default_nettype wire

// ----- src/tft_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Shared by the rate and the weighted average divisions; no package needed.
`default_nettype none

module tft_div #(
   parameter int DVD_W = 58,
   parameter int DSR_W = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DSR_W-1:0] divisor,
   output logic                  done,
   output logic [DVD_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic             done_ff, done_in;
   logic [DSR_W:0]   rem_shift;
   logic [DSR_W:0]   rem_diff;
   logic             fits;

   // One trial subtraction per cycle; the dividend shifts out as the quotient shifts in.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DVD_W-1]};
      rem_diff  = rem_shift - {1'b0, dsr_ff};
      fits      = rem_shift >= {1'b0, dsr_ff};
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      done_in   = 1'b0;
      if (start) begin
         cnt_in = CNT_W'(DVD_W);
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         rem_in  = fits ? rem_diff[DSR_W-1:0] : rem_shift[DSR_W-1:0];
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // Operands and partial results.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- src/tft_hist.sv -----
// Sample history ring buffer and the serial walk that forms the weighted sum.
// Depends on tft_pkg for the rate width and the command struct.
`default_nettype none

module tft_hist import tft_pkg::*; #(
   parameter int RECORDS = 8,
   parameter int LEN_W   = 4,
   parameter int WSUM_W  = 56
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire hist_ctl_type             ctl,
   input  wire logic signed [RATE_W-1:0] push_data,
   output logic [LEN_W-1:0]              len,
   output logic                          walk_done,
   output logic signed [WSUM_W-1:0]      wsum
);

   localparam int PTR_W = (RECORDS > 1) ? $clog2(RECORDS) : 1;
   localparam int PRE_W = RATE_W + LEN_W;

   logic signed [RATE_W-1:0] mem [RECORDS];

   logic [PTR_W-1:0]         wp_ff, wp_in, wp_next;
   logic [PTR_W-1:0]         rd_ff, rd_in, rd_dec;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [LEN_W-1:0]         idx_ff, idx_in;
   logic                     issue_ff, issue_in;
   logic                     walking_ff, walking_in;
   logic signed [RATE_W-1:0] rdata_ff;
   logic signed [PRE_W-1:0]  pre_ff, pre_in, pre_sum;
   logic signed [WSUM_W-1:0] wsum_ff, wsum_in;

   // Ring pointers step with wrap at the buffer depth.
   assign wp_next = (wp_ff == PTR_W'(RECORDS - 1)) ? '0 : wp_ff + 1'b1;
   assign rd_dec  = (rd_ff == '0) ? PTR_W'(RECORDS - 1) : rd_ff - 1'b1;
   assign pre_sum = pre_ff + PRE_W'(rdata_ff);

   // The walk runs newest to oldest. Adding the running prefix sum once per entry
   // gives the newest sample weight n and the oldest weight one.
   assign walk_done = walking_ff && (idx_ff == len_ff) && !issue_ff;

   always_comb begin
      wp_in      = wp_ff;
      len_in     = len_ff;
      rd_in      = rd_ff;
      idx_in     = idx_ff;
      issue_in   = 1'b0;
      walking_in = walking_ff;
      pre_in     = pre_ff;
      wsum_in    = wsum_ff;
      if (ctl.clear) begin
         len_in = '0;
      end
      if (ctl.push) begin
         wp_in = wp_next;
         if (len_ff != LEN_W'(RECORDS)) begin
            len_in = len_ff + 1'b1;
         end
      end
      if (ctl.walk_start) begin
         walking_in = 1'b1;
         idx_in     = '0;
         rd_in      = ctl.push ? wp_next : wp_ff;
         pre_in     = '0;
         wsum_in    = '0;
      end else if (walking_ff) begin
         if (issue_ff) begin
            pre_in  = pre_sum;
            wsum_in = wsum_ff + WSUM_W'(pre_sum);
         end
         if (idx_ff != len_ff) begin
            issue_in = 1'b1;
            idx_in   = idx_ff + 1'b1;
            rd_in    = rd_dec;
         end
         if (walk_done) begin
            walking_in = 1'b0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         len_ff     <= '0;
         idx_ff     <= '0;
         issue_ff   <= 1'b0;
         walking_ff <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         len_ff     <= len_in;
         idx_ff     <= idx_in;
         issue_ff   <= issue_in;
         walking_ff <= walking_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rd_ff   <= rd_in;
      pre_ff  <= pre_in;
      wsum_ff <= wsum_in;
   end

   // History memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[wp_next] <= push_data;
      end
      rdata_ff <= mem[rd_ff];
   end

   assign len  = len_ff;
   assign wsum = wsum_ff;

endmodule

`default_nettype wire

// ----- src/throughput_floor_tracker.sv -----
// Top level of the throughput floor tracker: sequencer, datapath and register port.
// Depends on tft_pkg, tft_req_if, tft_rsp_if, tft_div and tft_hist.
`default_nettype none

// A tick request turns the byte counter delta into a rate in bytes per second, pushes
// it into a history of RECORDS samples and returns the rate, the linearly weighted
// average (newest sample weighted highest), the running average and a speed floor
// that ratchets up to ratio/65536 times the average. Start clears the history and resets
// the floor to the minimum floor, resume reloads the counter, and short ticks are
// dropped; these leave the sequencer idle and give no result. An accepted tick
// occupies the block until its result is loaded into the output register, and no
// request is taken meanwhile; that load waits while the previous result still waits
// in the output register. The dividend of the bit-serial divider is 58 bits wide for
// RECORDS up to 31, 60 up to 63 and 62 at 64. Both divisions go through the one
// shared divider at one bit a cycle, which takes most of a tick's time, and the
// weighted sum reads the history memory one entry a cycle. A finished result waits
// in an output register, so the next request is taken while it is still pending.
module throughput_floor_tracker import tft_pkg::*; #(
   parameter int RECORDS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   tft_req_if.sink                    req_ch,
   tft_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   localparam int LEN_W  = $clog2(RECORDS + 1);
   localparam int WSUM_W = RATE_W + 2 * LEN_W;
   localparam int WDIV_W = 2 * LEN_W;
   localparam int DVD_W  = (PROD_W > WSUM_W) ? PROD_W : WSUM_W;
   localparam int DSR_W  = ELAPSED_W;
   localparam int HI_W   = DVD_W - FLOOR_W;
   localparam int MUL_W  = FLOOR_W + RATIO_W;

   // Sequencer and configuration.
   state_type              state_ff, state_in;
   logic [INTERVAL_W-1:0]  min_interval_ff, min_interval_in;
   logic [MIN_FLOOR_W-1:0] min_floor_ff, min_floor_in;
   logic [RATIO_W-1:0]     ratio_ff, ratio_in;
   reg_index_type          csr_index;
   logic                   csr_write;

   // Tracker state and per-request working registers.
   logic [COUNT_W-1:0]       last_count_ff, last_count_in;
   logic                     neg_ff, neg_in;
   logic [COUNT_W-1:0]       mag_ff, mag_in;
   logic [ELAPSED_W-1:0]     elapsed_ff, elapsed_in;
   logic signed [RATE_W-1:0] sample_ff, sample_in;
   logic signed [RATE_W-1:0] avg_ff, avg_in;
   logic signed [RATE_W-1:0] smoothed_ff, smoothed_in;
   logic [FLOOR_W-1:0]       floor_ff, floor_in;
   logic [MUL_W-1:0]         prod_ff, prod_in;
   logic                     raise_ff, raise_in;

   // Output register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [RATE_W-1:0] rsp_sample_ff, rsp_avg_ff, rsp_smoothed_ff;
   logic [FLOOR_W-1:0]       rsp_floor_ff;
   logic                     rsp_below_ff;

   // Sequencer outputs.
   logic         req_ready;
   logic         div_start;
   logic [DVD_W-1:0] div_dividend;
   logic [DSR_W-1:0] div_divisor;
   hist_ctl_type hist_ctl;
   logic         out_load;

   // Shared unit and history signals.
   logic                     div_done;
   logic [DVD_W-1:0]         div_quotient;
   logic [LEN_W-1:0]         hist_len;
   logic                     walk_done;
   logic signed [WSUM_W-1:0] wsum;

   // Combinational datapath values.
   logic                     tick_ok;
   logic signed [COUNT_W:0]  delta;
   logic [COUNT_W:0]         delta_abs;
   logic [PROD_W-1:0]        scaled;
   logic [WSUM_W-1:0]        wsum_mag;
   logic [WDIV_W-1:0]        wdiv_prod;
   logic [WDIV_W-1:0]        wdiv;
   logic [HI_W-1:0]          quo_hi;
   logic [RATE_W-1:0]        quo_low;
   logic                     pos_ovf, neg_ovf;
   logic signed [RATE_W-1:0] sample_new;
   logic signed [RATE_W-1:0] avg_new;
   logic signed [RATE_W:0]   smooth_sum, smooth_adj;
   logic [FLOOR_W-1:0]       cand;
   logic [FLOOR_W-1:0]       floor_next;
   logic                     below_next;

   // Shared bit-serial divider.
   tft_div #(
      .DVD_W (DVD_W),
      .DSR_W (DSR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Sample history and weighted-sum walk.
   tft_hist #(
      .RECORDS (RECORDS),
      .LEN_W   (LEN_W),
      .WSUM_W  (WSUM_W)
   ) u_hist (
      .clock     (clock),
      .reset     (reset),
      .ctl       (hist_ctl),
      .push_data (sample_ff),
      .len       (hist_len),
      .walk_done (walk_done),
      .wsum      (wsum)
   );

   // Request qualification and the signed counter delta.
   assign tick_ok   = (req_ch.mode == MODE_TICK) && (req_ch.elapsed_ms != '0) &&
                      (req_ch.elapsed_ms >= ELAPSED_W'(min_interval_ff));
   assign delta     = $signed({1'b0, req_ch.byte_count}) - $signed({1'b0, last_count_ff});
   assign delta_abs = delta[COUNT_W] ? (COUNT_W+1)'(0) - delta : delta;
   assign scaled    = PROD_W'(mag_ff) * PROD_W'(RATE_SCALE);

   // Weighted sum magnitude and the sum of weights n(n+1)/2.
   assign wsum_mag  = wsum[WSUM_W-1] ? WSUM_W'(0) - wsum : wsum;
   assign wdiv_prod = WDIV_W'(hist_len) * (WDIV_W'(hist_len) + WDIV_W'(1));
   assign wdiv      = wdiv_prod >> 1;

   // Signed rate from the magnitude quotient, saturated to the result width.
   assign quo_hi     = div_quotient[DVD_W-1:FLOOR_W];
   assign quo_low    = div_quotient[RATE_W-1:0];
   assign pos_ovf    = |quo_hi;
   assign neg_ovf    = (quo_hi > HI_W'(1)) ||
                       ((quo_hi == HI_W'(1)) && (|div_quotient[FLOOR_W-1:0]));
   assign sample_new = neg_ff ? (neg_ovf ? RATE_MIN : $signed(RATE_W'(0) - quo_low))
                              : (pos_ovf ? RATE_MAX : $signed(quo_low));

   // Average keeps the sign of the weighted sum; the running average halves toward zero.
   assign avg_new    = wsum[WSUM_W-1] ? $signed(RATE_W'(0) - quo_low) : $signed(quo_low);
   assign smooth_sum = {smoothed_ff[RATE_W-1], smoothed_ff} + {avg_new[RATE_W-1], avg_new};
   assign smooth_adj = smooth_sum + $signed({{RATE_W{1'b0}}, smooth_sum[RATE_W]});

   // Floor candidate and the ratchet.
   assign cand       = prod_ff[MUL_W-1:RATIO_W];
   assign floor_next = (raise_ff && (cand > floor_ff)) ? cand : floor_ff;
   assign below_next = smoothed_ff[RATE_W-1] || (smoothed_ff[FLOOR_W-1:0] < floor_next);

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid && tick_ok) begin
               state_in = ST_RATE_GO;
            end
         end
         ST_RATE_GO: begin
            state_in = ST_RATE_WAIT;
         end
         ST_RATE_WAIT: begin
            if (div_done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_AVG_GO;
            end
         end
         ST_AVG_GO: begin
            state_in = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_done) begin
               state_in = ST_FLOOR_MUL;
            end
         end
         ST_FLOOR_MUL: begin
            state_in = ST_FLOOR;
         end
         ST_FLOOR: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output decode of the sequencer.
   always_comb begin
      req_ready    = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      hist_ctl     = '0;
      out_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            hist_ctl.clear = req_ch.valid && (req_ch.mode == MODE_START);
         end
         ST_RATE_GO: begin
            div_start    = 1'b1;
            div_dividend = DVD_W'(scaled);
            div_divisor  = elapsed_ff;
         end
         ST_PUSH: begin
            hist_ctl.push       = 1'b1;
            hist_ctl.walk_start = 1'b1;
         end
         ST_AVG_GO: begin
            div_start    = 1'b1;
            div_dividend = DVD_W'(wsum_mag);
            div_divisor  = DSR_W'(wdiv);
         end
         ST_FLOOR: begin
            out_load = !rsp_valid_ff || rsp_ch.ready;
         end
         default: begin
         end
      endcase
   end

   // Register port: writes land on the access phase, reads return the register.
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      min_interval_in = min_interval_ff;
      min_floor_in    = min_floor_ff;
      ratio_in        = ratio_ff;
      csr_prdata      = '0;
      case (csr_index)
         REG_MIN_INTERVAL: begin
            csr_prdata = CSR_DATA_W'(min_interval_ff);
            if (csr_write) begin
               min_interval_in = csr_pwdata[INTERVAL_W-1:0];
            end
         end
         REG_MIN_FLOOR: begin
            csr_prdata = CSR_DATA_W'(min_floor_ff);
            if (csr_write) begin
               min_floor_in = csr_pwdata[MIN_FLOOR_W-1:0];
            end
         end
         REG_FLOOR_RATIO: begin
            csr_prdata = CSR_DATA_W'(ratio_ff);
            if (csr_write) begin
               ratio_in = csr_pwdata[RATIO_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      last_count_in = last_count_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      elapsed_in    = elapsed_ff;
      sample_in     = sample_ff;
      avg_in        = avg_ff;
      smoothed_in   = smoothed_ff;
      floor_in      = floor_ff;
      prod_in       = prod_ff;
      raise_in      = raise_ff;

      // Requests are taken only while idle.
      if ((state_ff == ST_IDLE) && req_ch.valid) begin
         case (req_ch.mode)
            MODE_TICK: begin
               if (tick_ok) begin
                  last_count_in = req_ch.byte_count;
                  neg_in        = delta[COUNT_W];
                  mag_in        = delta_abs[COUNT_W-1:0];
                  elapsed_in    = req_ch.elapsed_ms;
               end
            end
            MODE_START: begin
               last_count_in = '0;
               floor_in      = FLOOR_W'(min_floor_ff);
            end
            MODE_RESUME: begin
               last_count_in = req_ch.byte_count;
            end
            default: begin
            end
         endcase
      end

      // Rate quotient arrives.
      if ((state_ff == ST_RATE_WAIT) && div_done) begin
         sample_in = sample_new;
      end

      // Average quotient arrives; the running average follows at once.
      if ((state_ff == ST_AVG_WAIT) && div_done) begin
         avg_in      = avg_new;
         smoothed_in = smooth_adj[RATE_W:1];
      end

      // Floor candidate product, registered before the compare.
      if (state_ff == ST_FLOOR_MUL) begin
         prod_in  = avg_ff[FLOOR_W-1:0] * ratio_ff;
         raise_in = !avg_ff[RATE_W-1] &&
                    (avg_ff[FLOOR_W-1:0] >= FLOOR_W'(min_floor_ff));
      end

      if (out_load) begin
         floor_in = floor_next;
      end
   end

   // Result register stays full until the consumer takes it.
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ch.ready);

   // Control state, configuration and tracker state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         min_interval_ff <= RST_MIN_INTERVAL;
         min_floor_ff    <= RST_MIN_FLOOR;
         ratio_ff        <= RST_FLOOR_RATIO;
         last_count_ff   <= '0;
         smoothed_ff     <= '0;
         floor_ff        <= FLOOR_W'(RST_MIN_FLOOR);
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         min_interval_ff <= min_interval_in;
         min_floor_ff    <= min_floor_in;
         ratio_ff        <= ratio_in;
         last_count_ff   <= last_count_in;
         smoothed_ff     <= smoothed_in;
         floor_ff        <= floor_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      elapsed_ff <= elapsed_in;
      sample_ff  <= sample_in;
      avg_ff     <= avg_in;
      prod_ff    <= prod_in;
      raise_ff   <= raise_in;
      if (out_load) begin
         rsp_sample_ff   <= sample_ff;
         rsp_avg_ff      <= avg_ff;
         rsp_smoothed_ff <= smoothed_ff;
         rsp_floor_ff    <= floor_next;
         rsp_below_ff    <= below_next;
      end
   end

   // Channel outputs.
   assign req_ch.ready        = req_ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.sample_bps   = rsp_sample_ff;
   assign rsp_ch.average_bps  = rsp_avg_ff;
   assign rsp_ch.smoothed_bps = rsp_smoothed_ff;
   assign rsp_ch.floor_bps    = rsp_floor_ff;
   assign rsp_ch.below_floor  = rsp_below_ff;

endmodule

`default_nettype wire

// ----- src/tft_sva.sv -----
// Port-level checks of the throughput floor tracker, bound to the top level.
// Depends on tft_pkg and the assertion macros in throughput_floor_tracker_defines.svh.
`default_nettype none
`include "throughput_floor_tracker_defines.svh"

module tft_sva import tft_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic [MODE_W-1:0]        req_mode,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic signed [RATE_W-1:0] rsp_smoothed,
   input wire logic [FLOOR_W-1:0]       rsp_floor,
   input wire logic                     rsp_below
);

   logic ctrl_req;
   logic below_want;

   // A start or resume request taken at this edge.
   assign ctrl_req   = req_valid && req_ready &&
                       ((req_mode == MODE_START) || (req_mode == MODE_RESUME));

   // Flag value implied by the reported running average and floor.
   assign below_want = rsp_smoothed[RATE_W-1] || (rsp_smoothed[FLOOR_W-1:0] < rsp_floor);

   // A pending result is held until it is taken.
   `TFT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // Start and resume requests finish in the cycle they are taken.
   `TFT_ASSERT_NEXT(a_ctrl_req_quick, ctrl_req, req_ready)

   // The below-floor flag agrees with the reported running average and floor.
   `TFT_ASSERT_IMPL(a_below_flag, rsp_valid, rsp_below == below_want)

   // Reset leaves no result pending and the request side open.
   `TFT_ASSERT_RESET(a_reset_clean, reset, !rsp_valid && req_ready)

endmodule

bind throughput_floor_tracker tft_sva u_tft_sva (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_mode     (req_ch.mode),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_smoothed (rsp_ch.smoothed_bps),
   .rsp_floor    (rsp_ch.floor_bps),
   .rsp_below    (rsp_ch.below_floor)
);

`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for the throughput floor tracker: directed and random tick, start and resume
// requests, checked against a rate predictor kept in the bench. Depends on tft_pkg,
// tft_req_if, tft_rsp_if and the throughput_floor_tracker top level.
`timescale 1ns / 1ps

module tb;
   import tft_pkg::*;

   localparam int RECORDS      = 8;
   localparam int DRAIN_CYCLES = 200;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int MAX_REPORTS  = 10;
   localparam int REG_SPARE    = 3;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam longint RATE_HI = longint'(RATE_MAX);
   localparam longint RATE_LO = longint'(RATE_MIN);

   typedef struct packed {
      logic signed [RATE_W-1:0] sample_bps;
      logic signed [RATE_W-1:0] average_bps;
      logic signed [RATE_W-1:0] smoothed_bps;
      logic [FLOOR_W-1:0]       floor_bps;
      logic                     below_floor;
   } rate_result_t;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   tft_req_if req_if();
   tft_rsp_if rsp_if();

   throughput_floor_tracker #(.RECORDS(RECORDS)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if.sink),
      .rsp_ch      (rsp_if.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Register copies and rate tracking state of the predictor.
   logic [INTERVAL_W-1:0]  cfg_min_interval;
   logic [MIN_FLOOR_W-1:0] cfg_min_floor;
   logic [RATIO_W-1:0]     cfg_floor_ratio;
   logic [COUNT_W-1:0]     last_count_model;
   longint                 rate_history [RECORDS];
   int                     history_fill;
   longint                 smoothed_rate;
   longint                 floor_level;

   rate_result_t expected_results [$];
   int           mismatch_count;
   int           burst_left;

   // Free running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard limit on the whole run.
   initial begin
      #30_000_000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic reset_model();
      cfg_min_interval = RST_MIN_INTERVAL;
      cfg_min_floor    = RST_MIN_FLOOR;
      cfg_floor_ratio  = RST_FLOOR_RATIO;
      last_count_model = '0;
      history_fill     = 0;
      smoothed_rate    = 0;
      floor_level      = longint'(RST_MIN_FLOOR);
      foreach (rate_history[i]) rate_history[i] = 0;
   endtask

   // Predicts the effect of one request; returns 1 when it produces a result.
   function automatic bit model_request(input logic [MODE_W-1:0] mode,
                                        input logic [ELAPSED_W-1:0] elapsed,
                                        input logic [COUNT_W-1:0] count,
                                        output rate_result_t res);
      longint delta;
      longint sample;
      longint wsum;
      longint wdiv;
      longint avg;
      longint cand;
      res = '0;
      case (mode)
         MODE_START: begin
            last_count_model = '0;
            history_fill     = 0;
            floor_level      = $signed({32'd0, cfg_min_floor});
            return 0;
         end
         MODE_RESUME: begin
            last_count_model = count;
            return 0;
         end
         MODE_TICK: ;
         default: return 0;
      endcase
      // Short ticks leave everything untouched.
      if (elapsed == 0 || elapsed < cfg_min_interval) return 0;

      delta = $signed({16'd0, count}) - $signed({16'd0, last_count_model});
      last_count_model = count;
      sample = (delta * 1000) / $signed({32'd0, elapsed});
      if (sample > RATE_HI) sample = RATE_HI;
      if (sample < RATE_LO) sample = RATE_LO;

      // Newest sample goes in front and carries the highest weight.
      for (int i = RECORDS - 1; i > 0; i--) rate_history[i] = rate_history[i - 1];
      rate_history[0] = sample;
      if (history_fill < RECORDS) history_fill++;
      wsum = 0;
      for (int i = 0; i < history_fill; i++) wsum += rate_history[i] * (history_fill - i);
      wdiv = history_fill * (history_fill + 1) / 2;
      avg  = wsum / wdiv;

      smoothed_rate = (smoothed_rate + avg) / 2;

      // The floor only ratchets upward, and only on a large enough average.
      if (avg >= 0 && avg >= $signed({32'd0, cfg_min_floor})) begin
         cand = (avg * $signed({48'd0, cfg_floor_ratio})) >>> 16;
         if (cand > floor_level) floor_level = cand;
      end

      res.sample_bps   = sample[RATE_W-1:0];
      res.average_bps  = avg[RATE_W-1:0];
      res.smoothed_bps = smoothed_rate[RATE_W-1:0];
      res.floor_bps    = floor_level[FLOOR_W-1:0];
      res.below_floor  = smoothed_rate < floor_level;
      return 1;
   endfunction

   task automatic report_failure(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t: %s: expected %h, actual %h", $time, what, want, got);
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) report_failure(what, want, got);
   endtask

   // Every accepted result is matched against the oldest pending expectation.
   always @(posedge clock) begin : check_results
      rate_result_t want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            report_failure("result without a pending request", '0, rsp_if.sample_bps);
         end else begin
            want = expected_results.pop_front();
            check_field("sample_bps", want.sample_bps, rsp_if.sample_bps);
            check_field("average_bps", want.average_bps, rsp_if.average_bps);
            check_field("smoothed_bps", want.smoothed_bps, rsp_if.smoothed_bps);
            check_field("floor_bps", want.floor_bps, rsp_if.floor_bps);
            check_field("below_floor", want.below_floor, rsp_if.below_floor);
         end
      end
   end

   // The result side stalls in stretches: open, coin flip, shut, or one cycle in four.
   initial begin : result_stall_pattern
      int kind;
      int len;
      rsp_if.ready = 1'b0;
      forever begin
         kind = $urandom_range(0, 3);
         len  = $urandom_range(1, 60);
         for (int i = 0; i < len; i++) begin
            @(negedge clock);
            case (kind)
               0: rsp_if.ready = 1'b1;
               1: rsp_if.ready = 1'($urandom_range(0, 1));
               2: rsp_if.ready = 1'b0;
               default: rsp_if.ready = (i % 4 == 3);
            endcase
         end
      end
   end

   // Sends one request, inserting a random gap whenever a burst runs out.
   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic [ELAPSED_W-1:0] elapsed,
                               input logic [COUNT_W-1:0] count);
      rate_result_t res;
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         req_if.valid = 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(negedge clock);
         // Mostly short bursts, now and then a long run without any gap.
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 6);
      end
      burst_left--;
      req_if.valid      = 1'b1;
      req_if.mode       = mode;
      req_if.elapsed_ms = elapsed;
      req_if.byte_count = count;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (model_request(mode, elapsed, count, res)) expected_results.push_back(res);
   endtask

   // Stops sending and waits until the block has nothing left in flight.
   task automatic drain_results();
      int waited;
      waited = 0;
      @(negedge clock);
      req_if.valid = 1'b0;
      while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input int index, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_W'(index * 4);
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (index)
         REG_MIN_INTERVAL: cfg_min_interval = value[INTERVAL_W-1:0];
         REG_MIN_FLOOR:    cfg_min_floor    = value[MIN_FLOOR_W-1:0];
         REG_FLOOR_RATIO:  cfg_floor_ratio  = value[RATIO_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic apply_settings(input logic [INTERVAL_W-1:0] interval,
                                 input logic [MIN_FLOOR_W-1:0] min_floor,
                                 input logic [RATIO_W-1:0] ratio);
      drain_results();
      csr_write(REG_MIN_INTERVAL, CSR_DATA_W'(interval));
      csr_write(REG_MIN_FLOOR, min_floor);
      csr_write(REG_FLOOR_RATIO, CSR_DATA_W'(ratio));
   endtask

   // Zero elapsed, one below the minimum, the unknown kind, then exactly the minimum.
   task automatic test_short_ticks();
      send_request(MODE_TICK, 32'd0, 48'd5000);
      send_request(MODE_TICK, 32'd99, 48'd5000);
      send_request(MODE_UNUSED, 32'd500, 48'd5000);
      send_request(MODE_TICK, 32'd100, 48'd100000);
   endtask

   // Rising rates past the history depth, so the oldest sample drops out.
   task automatic test_history_fill();
      for (int k = 0; k < RECORDS + 1; k++)
         send_request(MODE_TICK, 32'(100 + 37 * k), last_count_model + 48'(2000000 * (k + 1)));
   endtask

   // A counter that falls gives a negative rate and leaves the floor alone.
   task automatic test_falling_counter();
      send_request(MODE_RESUME, 32'd0, 48'hFFFF_FFFF_FFFF);
      send_request(MODE_TICK, 32'd1000, 48'd12345);
   endtask

   // One millisecond intervals push the rate into both saturation limits; a tick with the longest interval follows.
   task automatic test_rate_saturation();
      apply_settings(16'd1, cfg_min_floor, cfg_floor_ratio);
      send_request(MODE_RESUME, 32'd0, 48'd0);
      send_request(MODE_TICK, 32'd1, 48'hFFFF_FFFF_FFFF);
      send_request(MODE_TICK, 32'd1, 48'd0);
      send_request(MODE_TICK, 32'hFFFF_FFFF, 48'h8000_0000_0000);
   endtask

   // A write past the last register must not disturb any setting.
   task automatic test_spare_register();
      drain_results();
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
   endtask

   // Start clears the history and resets the floor to the minimum but keeps the running average.
   task automatic test_start_clears();
      send_request(MODE_START, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      send_request(MODE_TICK, 32'd250, 48'd5000000);
   endtask

   // Mostly well-formed tick streams, with starts, resumes, short ticks and noise.
   task automatic test_random_traffic(input int target);
      int counted;
      int pick;
      int shift;
      logic [63:0] delta;
      logic [ELAPSED_W-1:0] elapsed;
      logic [COUNT_W-1:0] count;
      counted = 0;
      while (counted < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            send_request(MODE_START, $urandom, COUNT_W'({$urandom, $urandom}));
            counted++;
         end else if (pick < 6) begin
            send_request(MODE_RESUME, $urandom, COUNT_W'({$urandom, $urandom}));
            counted++;
         end else if (pick < 8) begin
            send_request(MODE_UNUSED, $urandom, COUNT_W'({$urandom, $urandom}));
         end else if (pick < 14) begin
            elapsed = $urandom_range(0, cfg_min_interval - 1);
            send_request(MODE_TICK, elapsed, last_count_model + 48'($urandom_range(0, 1000)));
         end else if (pick < 18) begin
            // Fully random fields to reach every bit of both inputs.
            elapsed = $urandom;
            if (elapsed != 0 && elapsed >= cfg_min_interval) counted++;
            send_request(MODE_TICK, elapsed, COUNT_W'({$urandom, $urandom}));
         end else begin
            shift = $urandom_range(0, 36);
            delta = {$urandom, $urandom} & ((64'd1 << shift) - 1);
            count = ($urandom_range(0, 19) == 0) ? last_count_model - delta[COUNT_W-1:0]
                                                 : last_count_model + delta[COUNT_W-1:0];
            elapsed = cfg_min_interval + $urandom_range(0, 400);
            send_request(MODE_TICK, elapsed, count);
            counted++;
         end
      end
   endtask

   initial begin : run_tests
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.mode       = MODE_TICK;
      req_if.elapsed_ms = '0;
      req_if.byte_count = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      mismatch_count    = 0;
      burst_left        = 0;
      reset_model();
      repeat (12) @(negedge clock);
      reset = 1'b0;

      test_short_ticks();
      test_history_fill();
      test_falling_counter();
      test_rate_saturation();
      test_spare_register();
      test_start_clears();

      // Random phases: defaults, both extremes, then two random settings.
      apply_settings(RST_MIN_INTERVAL, RST_MIN_FLOOR, RST_FLOOR_RATIO);
      test_random_traffic(200);
      apply_settings(16'd1, 32'd0, 16'hFFFF);
      test_random_traffic(200);
      apply_settings(16'hFFFF, 32'hFFFF_FFFF, 16'd0);
      test_random_traffic(200);
      apply_settings(INTERVAL_W'($urandom_range(1, 500)), $urandom_range(0, 1 << 24),
                     RATIO_W'($urandom));
      test_random_traffic(200);
      apply_settings(INTERVAL_W'($urandom_range(50, 200)), $urandom, RATIO_W'($urandom));
      test_random_traffic(200);

      drain_results();
      if (expected_results.size() != 0)
         report_failure("results never returned", expected_results.size(), '0);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
